// ===== rtl/ax25_wide_n_digipeater_top_assert.svh =====
// Assertion macros for the WIDEn-N digipeater top level
`ifndef AX25_WIDE_N_DIGIPEATER_TOP_ASSERT_SVH
`define AX25_WIDE_N_DIGIPEATER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define AX25WD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define AX25WD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ax25wd_pkg.sv =====
// Shared types, constants and helper functions of the WIDEn-N digipeater
package ax25wd_pkg;

  localparam int MAX_PATH_DEF = 6;
  localparam int HDR_FIXED    = 14;   // destination + source entries
  localparam int ENTRY_LEN    = 7;
  localparam int NAME_LEN     = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;

  localparam logic [7:0] SSID_MASK = 8'h1E;
  localparam logic [7:0] KEEP_MASK = 8'hE1;
  localparam logic [7:0] H_BIT     = 8'h80;
  localparam logic [7:0] CALL_PAD  = 8'h40;
  localparam logic [2:0] SSID_HI   = 3'b111;  // upper bits of the inserted SSID byte
  localparam logic [7:0] SPACE     = 8'h20;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALIAS1_EN   = 3'd0,
    CFG_ALIAS1_NAME = 3'd1,
    CFG_ALIAS2_EN   = 3'd2,
    CFG_ALIAS2_NAME = 3'd3,
    CFG_OWN_CALL    = 3'd4,
    CFG_OWN_SSID    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_frame_end;
    logic       run_end;
  } out_t;

  typedef struct packed {
    logic        alias1_en;
    logic [47:0] alias1_name;
    logic        alias2_en;
    logic [47:0] alias2_name;
    logic [47:0] own_callsign;
    logic [3:0]  own_ssid;
  } cfg_t;

  // Per-byte control from the sequencer to the alias matcher
  typedef struct packed {
    logic       step;
    logic [2:0] k;      // byte index within the path entry
    logic [7:0] data;
  } match_ctl_t;

  typedef struct packed {
    logic hit1;
    logic hit2;
  } match_res_t;

  // Character k of a six-character name, first character in the top byte
  function automatic logic [7:0] name_char(input logic [47:0] name, input int k);
    return name[47-8*k -: 8];
  endfunction

  // True when no zero byte occurs at or before character k
  function automatic logic name_live(input logic [47:0] name, input int k);
    logic alive;
    alive = 1'b1;
    for (int j = 0; j < NAME_LEN; j++) begin
      if (j <= k && name_char(name, j) == 8'h00) alive = 1'b0;
    end
    return alive;
  endfunction

  // Alias character padded with spaces after the terminator
  function automatic logic [7:0] pad_char(input logic [47:0] name, input int k);
    return name_live(name, k) ? name_char(name, k) : SPACE;
  endfunction

  // Shifted callsign byte of the inserted entry
  function automatic logic [7:0] call_byte(input logic [47:0] call, input int k);
    logic [7:0] c;
    c = name_char(call, k);
    return name_live(call, k) ? {c[6:0], 1'b0} : CALL_PAD;
  endfunction

endpackage

// ===== rtl/ax25_wide_n_digipeater_top.sv =====
// A pass-through byte is held in the input holding register, then loaded into the output register.
// While collecting the header or passing through, a new input byte is taken only once the held one is consumed.
// A matched header bursts out at one byte per cycle while the output is not stalled, its first byte
// read from the header memory after the completing transaction, up to 14 + 7*(MAX_PATH_ENTRIES+1)
// bytes; input stalls after one held byte until the burst is done. Output stalls hold the burst.
// Reset: synchronous, active low; clears control and configuration, not the header memory.
`include "ax25_wide_n_digipeater_top_assert.svh"

module ax25_wide_n_digipeater_top #(
  parameter int MAX_PATH_ENTRIES = ax25wd_pkg::MAX_PATH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ax25wd_pkg::in_t                    in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ax25wd_pkg::out_t                   out_data,
  input  logic                               cfg_we,
  input  logic [ax25wd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ax25wd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int HDR_LEN = ax25wd_pkg::HDR_FIXED + ax25wd_pkg::ENTRY_LEN * MAX_PATH_ENTRIES;
  localparam int AW      = $clog2(HDR_LEN);
  localparam int PW      = $clog2(HDR_LEN + 1);
  localparam int EW      = $clog2(MAX_PATH_ENTRIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_CALL, S_ENTRY, S_FINAL} state_t;
  typedef enum logic [1:0] {M_COLLECT, M_PASS, M_DROP} mode_t;

  ax25wd_pkg::cfg_t       cfg;
  ax25wd_pkg::match_ctl_t mctl;
  ax25wd_pkg::match_res_t mres;

  state_t          state_r, state_nxt;
  mode_t           mode_r, mode_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [2:0]      k_r, k_nxt;
  logic [EW-1:0]   entry_r, entry_nxt;
  logic [AW-1:0]   start_r, start_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [2:0]      cidx_r, cidx_nxt;
  logic [7:0]      nb_r, nb_nxt;
  logic            last_r, last_nxt;
  logic            hold_valid_r, hold_valid_nxt;
  ax25wd_pkg::in_t hold_r, hold_nxt;
  logic            out_valid_r, out_valid_nxt;
  ax25wd_pkg::out_t out_r, out_nxt;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  logic            slot_free, load, consume;
  ax25wd_pkg::out_t load_data;
  logic [7:0]      hb, call_b, nb_calc;
  logic            hl, in_path, src_end, entry_done, hit, drop, call_on;
  logic [3:0]      ssid_dec;

  ax25wd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ax25wd_ram #(.WIDTH(8), .DEPTH(HDR_LEN)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r[AW-1:0]),
    .wdata (hb),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ax25wd_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .ctl   (mctl),
    .res   (mres)
  );

  // Header decode of the held byte
  assign hb         = hold_r.frame_byte;
  assign hl         = hold_r.frame_last;
  assign in_path    = pos_r >= PW'(ax25wd_pkg::HDR_FIXED);
  assign src_end    = pos_r == PW'(ax25wd_pkg::HDR_FIXED - 1);
  assign entry_done = in_path && (k_r == 3'(ax25wd_pkg::ENTRY_LEN - 1));
  assign hit        = entry_done && (mres.hit1 || mres.hit2);
  assign drop       = (src_end && ((!cfg.alias1_en && !cfg.alias2_en) || hb[0]))
                   || (entry_done && !hit
                       && (hb[0] || entry_r == EW'(MAX_PATH_ENTRIES - 1)));
  assign call_on    = ax25wd_pkg::name_char(cfg.own_callsign, 0) != 8'h00;

  // Rewritten SSID byte of the matched entry
  assign ssid_dec = hb[4:1] - 4'd1;
  assign nb_calc  = (hb & ax25wd_pkg::KEEP_MASK) | {3'b000, ssid_dec, 1'b0}
                  | ((ssid_dec == 4'd0) ? ax25wd_pkg::H_BIT : 8'h00);

  assign mctl.step = (state_r == S_IDLE) && hold_valid_r && (mode_r == M_COLLECT) && in_path;
  assign mctl.k    = k_r;
  assign mctl.data = hb;

  // Inserted own-callsign entry
  always_comb begin
    case (cidx_r)
      3'd0:    call_b = ax25wd_pkg::call_byte(cfg.own_callsign, 0);
      3'd1:    call_b = ax25wd_pkg::call_byte(cfg.own_callsign, 1);
      3'd2:    call_b = ax25wd_pkg::call_byte(cfg.own_callsign, 2);
      3'd3:    call_b = ax25wd_pkg::call_byte(cfg.own_callsign, 3);
      3'd4:    call_b = ax25wd_pkg::call_byte(cfg.own_callsign, 4);
      3'd5:    call_b = ax25wd_pkg::call_byte(cfg.own_callsign, 5);
      default: call_b = {ax25wd_pkg::SSID_HI, cfg.own_ssid, 1'b0};
    endcase
  end

  assign slot_free = !out_valid_r || out_ready;

  // Sequencer: collect, pass, drop and header burst
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    entry_nxt      = entry_r;
    start_nxt      = start_r;
    addr_nxt       = addr_r;
    cidx_nxt       = cidx_r;
    nb_nxt         = nb_r;
    last_nxt       = last_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = addr_r;
    consume        = 1'b0;
    load           = 1'b0;
    load_data      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (hold_valid_r) begin
          unique case (mode_r)
            M_PASS: begin
              if (slot_free) begin
                load                    = 1'b1;
                load_data.out_byte      = hb;
                load_data.out_frame_end = hl;
                load_data.run_end       = 1'b1;
                consume                 = 1'b1;
                if (hl) mode_nxt = M_COLLECT;
              end
            end
            M_DROP: begin
              consume = 1'b1;
              if (hl) mode_nxt = M_COLLECT;
            end
            M_COLLECT: begin
              consume = 1'b1;
              ram_we  = 1'b1;
              if (drop || hit || hl) begin
                pos_nxt   = '0;
                k_nxt     = '0;
                entry_nxt = '0;
              end
              if (drop) begin
                mode_nxt = hl ? M_COLLECT : M_DROP;
              end else if (hit) begin
                mode_nxt  = hl ? M_COLLECT : M_PASS;
                start_nxt = pos_r[AW-1:0] - AW'(ax25wd_pkg::ENTRY_LEN - 1);
                nb_nxt    = nb_calc;
                last_nxt  = hl;
                ram_re    = 1'b1;
                ram_raddr = '0;
                addr_nxt  = '0;
                state_nxt = S_HEAD;
              end else if (!hl) begin
                pos_nxt = pos_r + PW'(1);
                if (in_path) begin
                  if (entry_done) begin
                    k_nxt     = '0;
                    entry_nxt = entry_r + EW'(1);
                  end else begin
                    k_nxt = k_r + 3'd1;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_HEAD: begin
        if (slot_free) begin
          load               = 1'b1;
          load_data.out_byte = ram_rdata;
          if (addr_r == start_r - AW'(1)) begin
            if (call_on) begin
              cidx_nxt  = '0;
              state_nxt = S_CALL;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = start_r;
              addr_nxt  = start_r;
              state_nxt = S_ENTRY;
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = addr_r + AW'(1);
            addr_nxt  = addr_r + AW'(1);
          end
        end
      end
      S_CALL: begin
        if (slot_free) begin
          load               = 1'b1;
          load_data.out_byte = call_b;
          if (cidx_r == 3'(ax25wd_pkg::ENTRY_LEN - 1)) begin
            ram_re    = 1'b1;
            ram_raddr = start_r;
            addr_nxt  = start_r;
            state_nxt = S_ENTRY;
          end else begin
            cidx_nxt = cidx_r + 3'd1;
          end
        end
      end
      S_ENTRY: begin
        if (slot_free) begin
          load               = 1'b1;
          load_data.out_byte = ram_rdata;
          if (addr_r == start_r + AW'(ax25wd_pkg::NAME_LEN - 1)) begin
            state_nxt = S_FINAL;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = addr_r + AW'(1);
            addr_nxt  = addr_r + AW'(1);
          end
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          load                    = 1'b1;
          load_data.out_byte      = nb_r;
          load_data.out_frame_end = last_r;
          load_data.run_end       = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Input holding register
  assign in_ready = rst_n && !hold_valid_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (consume) begin
      hold_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      hold_valid_nxt = 1'b1;
      hold_nxt       = in_data;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = load_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= M_COLLECT;
      pos_r        <= '0;
      k_r          <= '0;
      entry_r      <= '0;
      cidx_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      pos_r        <= pos_nxt;
      k_r          <= k_nxt;
      entry_r      <= entry_nxt;
      cidx_r       <= cidx_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    start_r <= start_nxt;
    addr_r  <= addr_nxt;
    nb_r    <= nb_nxt;
    last_r  <= last_nxt;
    hold_r  <= hold_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `AX25WD_ASSERT_NOW(a_no_write_in_burst, state_r != S_IDLE, !ram_we,
    "header memory written during a burst")
  `AX25WD_ASSERT_NOW(a_write_in_range, ram_we, pos_r < PW'(HDR_LEN),
    "header write past the buffer")
  `AX25WD_ASSERT_NOW(a_frame_end_ends_run, out_valid_r && out_r.out_frame_end, out_r.run_end,
    "frame end without run end")
  `AX25WD_ASSERT_NXT(a_hold_kept_in_burst, hold_valid_r && state_r != S_IDLE, hold_valid_r,
    "held byte lost during a burst")

endmodule

// ===== rtl/ax25wd_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module ax25wd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ax25wd_cfg.sv =====
// Configuration register file of the digipeater
module ax25wd_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ax25wd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ax25wd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output ax25wd_pkg::cfg_t                     cfg
);

  ax25wd_pkg::cfg_t cfg_r;
  ax25wd_pkg::cfg_t cfg_nxt;

  // Register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (ax25wd_pkg::cfg_reg_e'(cfg_index))
        ax25wd_pkg::CFG_ALIAS1_EN:   cfg_nxt.alias1_en    = cfg_wdata[0];
        ax25wd_pkg::CFG_ALIAS1_NAME: cfg_nxt.alias1_name  = cfg_wdata[47:0];
        ax25wd_pkg::CFG_ALIAS2_EN:   cfg_nxt.alias2_en    = cfg_wdata[0];
        ax25wd_pkg::CFG_ALIAS2_NAME: cfg_nxt.alias2_name  = cfg_wdata[47:0];
        ax25wd_pkg::CFG_OWN_CALL:    cfg_nxt.own_callsign = cfg_wdata[47:0];
        ax25wd_pkg::CFG_OWN_SSID:    cfg_nxt.own_ssid     = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/ax25wd_match.sv =====
// Byte-by-byte alias matcher for one path entry
module ax25wd_match (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ax25wd_pkg::cfg_t           cfg,
  input  ax25wd_pkg::match_ctl_t     ctl,
  output ax25wd_pkg::match_res_t     res
);

  logic [7:0] pad1;
  logic [7:0] pad2;
  logic [7:0] shifted;
  logic       flag1_r, flag1_nxt;
  logic       flag2_r, flag2_nxt;
  logic       ssid_ok;

  // Padded alias character for the current entry byte
  always_comb begin
    case (ctl.k)
      3'd0: begin
        pad1 = ax25wd_pkg::pad_char(cfg.alias1_name, 0);
        pad2 = ax25wd_pkg::pad_char(cfg.alias2_name, 0);
      end
      3'd1: begin
        pad1 = ax25wd_pkg::pad_char(cfg.alias1_name, 1);
        pad2 = ax25wd_pkg::pad_char(cfg.alias2_name, 1);
      end
      3'd2: begin
        pad1 = ax25wd_pkg::pad_char(cfg.alias1_name, 2);
        pad2 = ax25wd_pkg::pad_char(cfg.alias2_name, 2);
      end
      3'd3: begin
        pad1 = ax25wd_pkg::pad_char(cfg.alias1_name, 3);
        pad2 = ax25wd_pkg::pad_char(cfg.alias2_name, 3);
      end
      3'd4: begin
        pad1 = ax25wd_pkg::pad_char(cfg.alias1_name, 4);
        pad2 = ax25wd_pkg::pad_char(cfg.alias2_name, 4);
      end
      3'd5: begin
        pad1 = ax25wd_pkg::pad_char(cfg.alias1_name, 5);
        pad2 = ax25wd_pkg::pad_char(cfg.alias2_name, 5);
      end
      default: begin
        pad1 = 8'h00;
        pad2 = 8'h00;
      end
    endcase
  end

  // Running match flags: first byte of an entry restarts them
  assign shifted   = {1'b0, ctl.data[7:1]};
  assign flag1_nxt = ((ctl.k == 3'd0) ? 1'b1 : flag1_r) && (shifted == pad1);
  assign flag2_nxt = ((ctl.k == 3'd0) ? 1'b1 : flag2_r) && (shifted == pad2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag1_r <= 1'b0;
      flag2_r <= 1'b0;
    end else if (ctl.step) begin
      flag1_r <= flag1_nxt;
      flag2_r <= flag2_nxt;
    end
  end

  // Valid on the SSID byte of an entry
  assign ssid_ok  = (ctl.data & ax25wd_pkg::SSID_MASK) != 8'h00;
  assign res.hit1 = cfg.alias1_en && flag1_r && ssid_ok;
  assign res.hit2 = cfg.alias2_en && flag2_r && ssid_ok;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the WIDEn-N digipeater path rewriter
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ax25wd_pkg::*;

  localparam int HDR_BYTES     = HDR_FIXED + ENTRY_LEN * MAX_PATH_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 20000000;
  localparam int HOLD_CYCLES   = 300;

  // index with no register behind it; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  localparam logic [47:0] ALIAS_W1 = {"WIDE1", 8'h00};
  localparam logic [47:0] ALIAS_W2 = {"WIDE2", 8'h00};
  localparam logic [47:0] MY_CALL  = "N0CALL";

  typedef enum logic [1:0] {HDR_COLLECT, HDR_PASS, HDR_DROP} frame_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // rewriter state mirrored by the predictor
  cfg_t        shadow_cfg = '0;
  frame_mode_e digi_mode  = HDR_COLLECT;
  int          hdr_fill   = 0;
  logic [7:0]  hdr_buf [0:HDR_BYTES-1];
  out_t        rewritten_q[$];

  logic [7:0]  frame_bytes[$];
  int          mismatches  = 0;
  int          live_items  = 0;
  int          cycle_count = 0;
  int          hold_req    = 0;
  bit          tx_idle     = 1'b1;
  bit          rx_idle     = 1'b1;

  ax25_wide_n_digipeater_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ax25_wide_n_digipeater_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // alias or callsign with the first zero byte and everything after it as spaces
  function automatic logic [47:0] space_pad(input logic [47:0] name);
    logic [47:0] res;
    logic        live;
    live = 1'b1;
    for (int k = 0; k < NAME_LEN; k++) begin
      if (name[47-8*k -: 8] == 8'h00) live = 1'b0;
      res[47-8*k -: 8] = live ? name[47-8*k -: 8] : 8'h20;
    end
    return res;
  endfunction

  function automatic bit entry_matches(input logic [47:0] name, input int start);
    logic [47:0] padded;
    if (hdr_buf[start+6][4:1] == 4'd0) return 1'b0;
    padded = space_pad(name);
    for (int k = 0; k < NAME_LEN; k++)
      if (padded[47-8*k -: 8] != {1'b0, hdr_buf[start+k][7:1]}) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_byte(input logic [7:0] v);
    out_t o;
    o.out_byte      = v;
    o.out_frame_end = 1'b0;
    o.run_end       = 1'b0;
    rewritten_q.push_back(o);
  endfunction

  // mark the tail of the run caused by one input byte
  function automatic void close_run(input logic lst);
    out_t o;
    o = rewritten_q.pop_back();
    o.out_frame_end = lst;
    o.run_end       = 1'b1;
    rewritten_q.push_back(o);
  endfunction

  function automatic void rewrite_predict(input in_t it);
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] nb;
    logic [3:0] s;
    logic       lst;
    logic       live;
    bit         drop;
    bit         hit;
    int         start;
    int         e;
    b     = it.frame_byte;
    lst   = it.frame_last;
    drop  = 1'b0;
    hit   = 1'b0;
    start = 0;
    if (digi_mode == HDR_PASS) begin
      push_byte(b);
      close_run(lst);
      if (lst) begin
        digi_mode = HDR_COLLECT;
        hdr_fill  = 0;
      end
      return;
    end
    if (digi_mode == HDR_DROP) begin
      if (lst) begin
        digi_mode = HDR_COLLECT;
        hdr_fill  = 0;
      end
      return;
    end
    if (hdr_fill >= HDR_BYTES) hdr_fill = 0;
    hdr_buf[hdr_fill] = b;
    hdr_fill++;
    // decisions fall on the source end and on each completed path entry
    if (hdr_fill == HDR_FIXED) begin
      drop = (!shadow_cfg.alias1_en && !shadow_cfg.alias2_en) || b[0];
    end else if (hdr_fill > HDR_FIXED && (hdr_fill - HDR_FIXED) % ENTRY_LEN == 0) begin
      e     = (hdr_fill - HDR_FIXED) / ENTRY_LEN - 1;
      start = HDR_FIXED + ENTRY_LEN * e;
      if (shadow_cfg.alias1_en && entry_matches(shadow_cfg.alias1_name, start)) hit = 1'b1;
      else if (shadow_cfg.alias2_en && entry_matches(shadow_cfg.alias2_name, start)) hit = 1'b1;
      else if (b[0] || e + 1 >= MAX_PATH_DEF) drop = 1'b1;
    end
    if (drop) begin
      digi_mode = lst ? HDR_COLLECT : HDR_DROP;
      hdr_fill  = 0;
      return;
    end
    if (!hit) begin
      if (lst) begin
        digi_mode = HDR_COLLECT;
        hdr_fill  = 0;
      end
      return;
    end
    // header burst: entries before the match, own entry, rewritten match
    for (int k = 0; k < start; k++) push_byte(hdr_buf[k]);
    if (shadow_cfg.own_callsign[47:40] != 8'h00) begin
      live = 1'b1;
      for (int k = 0; k < NAME_LEN; k++) begin
        c = shadow_cfg.own_callsign[47-8*k -: 8];
        if (c == 8'h00) live = 1'b0;
        push_byte(live ? {c[6:0], 1'b0} : 8'h40);
      end
      push_byte({3'b111, shadow_cfg.own_ssid, 1'b0});
    end
    for (int k = 0; k < NAME_LEN; k++) push_byte(hdr_buf[start+k]);
    s  = hdr_buf[start+6][4:1] - 4'd1;
    nb = (hdr_buf[start+6] & 8'hE1) | {3'b000, s, 1'b0};
    if (s == 4'd0) nb[7] = 1'b1;
    push_byte(nb);
    close_run(lst);
    digi_mode = lst ? HDR_COLLECT : HDR_PASS;
    hdr_fill  = 0;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : check_out
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rewritten_q.size() == 0) begin
        $display("%0t: unexpected transaction: byte %h end %b run %b", $time,
                 out_data.out_byte, out_data.out_frame_end, out_data.run_end);
        mismatches++;
      end else begin
        want = rewritten_q.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch: expected byte %h end %b run %b, got byte %h end %b run %b",
                   $time, want.out_byte, want.out_frame_end, want.run_end,
                   out_data.out_byte, out_data.out_frame_end, out_data.run_end);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- random helpers

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  function automatic logic [47:0] rand_call();
    logic [47:0] v;
    for (int k = 0; k < NAME_LEN; k++)
      v[47-8*k -: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                                   : 8'($urandom_range(8'h41, 8'h5A));
    return v;
  endfunction

  // zero-terminated name, junk allowed past the terminator
  function automatic logic [47:0] rand_alias();
    logic [47:0] v;
    int          len;
    v = rand48();
    if ($urandom_range(0, 7) == 0) return v;
    len = $urandom_range(0, 6);
    for (int k = 0; k < len; k++) v[47-8*k -: 8] = 8'($urandom_range(8'h41, 8'h5A));
    if (len < NAME_LEN) v[47-8*len -: 8] = 8'h00;
    return v;
  endfunction

  function automatic logic [47:0] rand_own();
    logic [47:0] v;
    int          r;
    r = $urandom_range(0, 4);
    v = (r == 1) ? rand_alias() : rand_call();
    if (r == 0) v[47:40] = 8'h00;
    return v;
  endfunction

  // ---------------------------------------------------------------- frame building

  function automatic void put_entry(input logic [47:0] name, input logic [3:0] ssid,
                                    input logic h, input logic endb, input logic lsb);
    for (int k = 0; k < NAME_LEN; k++) frame_bytes.push_back({name[46-8*k -: 7], lsb});
    frame_bytes.push_back({h, 2'b11, ssid, endb});
  endfunction

  function automatic void add_head(input logic src_end);
    frame_bytes.delete();
    put_entry("APRS  ", 4'd0, 1'b0, 1'b0, 1'b0);
    put_entry("N1AAA ", 4'd7, 1'b0, src_end, 1'b0);
  endfunction

  function automatic void add_payload(input int n);
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic lst);
    in_t it;
    int  gap;
    it.frame_byte = b;
    it.frame_last = lst;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (digi_mode != HDR_DROP) live_items++;
    rewrite_predict(it);
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // send frame_bytes, or only the first cut bytes when cut is nonzero
  task automatic send_frame(input int cut);
    int n;
    n = (cut > 0) ? cut : frame_bytes.size();
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
  endtask

  task automatic send_hit_frame(input logic [47:0] name, input logic [3:0] ssid,
                                input logic lsb);
    add_head(1'b0);
    put_entry(name, ssid, 1'b0, 1'b1, lsb);
    add_payload(2);
    send_frame(0);
  endtask

  // sender goes quiet until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ALIAS1_EN:   shadow_cfg.alias1_en    = val[0];
      CFG_ALIAS1_NAME: shadow_cfg.alias1_name  = val;
      CFG_ALIAS2_EN:   shadow_cfg.alias2_en    = val[0];
      CFG_ALIAS2_NAME: shadow_cfg.alias2_name  = val;
      CFG_OWN_CALL:    shadow_cfg.own_callsign = val;
      CFG_OWN_SSID:    shadow_cfg.own_ssid     = val[3:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper bits of the narrow registers carry random data
  task automatic set_config(input logic en1, input logic [47:0] name1, input logic en2,
                            input logic [47:0] name2, input logic [47:0] call,
                            input logic [3:0] ssid);
    logic [47:0] r;
    drain();
    r = rand48(); r[0] = en1;
    write_cfg(CFG_ALIAS1_EN, r);
    write_cfg(CFG_ALIAS1_NAME, name1);
    r = rand48(); r[0] = en2;
    write_cfg(CFG_ALIAS2_EN, r);
    write_cfg(CFG_ALIAS2_NAME, name2);
    write_cfg(CFG_OWN_CALL, call);
    r = rand48(); r[3:0] = ssid;
    write_cfg(CFG_OWN_SSID, r);
  endtask

  // receiver: random stalls plus an occasional long hold-off on request
  initial begin : rx_side
    int stall_left;
    int gap;
    out_ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        gap = rx_idle ? pick_gap() : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          stall_left = gap - 1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // out of reset both aliases are off, so every frame is dropped
  task automatic test_reset_state();
    send_hit_frame("WIDE1 ", 4'd1, 1'b0);
    add_head(1'b0);
    put_entry("WIDE2 ", 4'd2, 1'b0, 1'b1, 1'b0);
    add_payload(5);
    send_frame(0);
  endtask

  task automatic test_config_regs();
    set_config(1'b1, ALIAS_W1, 1'b1, ALIAS_W2, MY_CALL, 4'd7);
    send_hit_frame("WIDE1 ", 4'd1, 1'b0);
    // write to the spare index must leave the settings alone
    drain();
    write_cfg(CFG_IDX_SPARE, rand48());
    send_hit_frame("WIDE2 ", 4'd2, 1'b0);
  endtask

  task automatic test_alias_hits();
    // SSID runs out and H gets set; payload spans the byte extremes
    add_head(1'b0);
    put_entry("WIDE1 ", 4'd1, 1'b0, 1'b1, 1'b0);
    frame_bytes.push_back(8'h03);
    frame_bytes.push_back(8'hF0);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    send_frame(0);
    // first entry is no alias, second hits through alias 2
    add_head(1'b0);
    put_entry("RELAY ", 4'd3, 1'b1, 1'b0, 1'b0);
    put_entry("WIDE2 ", 4'd2, 1'b0, 1'b1, 1'b0);
    add_payload(3);
    send_frame(0);
    // top SSID, frame ends on the matched entry
    add_head(1'b0);
    put_entry("WIDE2 ", 4'd15, 1'b0, 1'b1, 1'b0);
    send_frame(0);
    // alias with SSID zero is skipped
    add_head(1'b0);
    put_entry("WIDE1 ", 4'd0, 1'b1, 1'b0, 1'b0);
    put_entry("WIDE2 ", 4'd1, 1'b0, 1'b1, 1'b0);
    add_payload(2);
    send_frame(0);
    // every control bit set, and low bits set in the name bytes
    add_head(1'b0);
    put_entry("WIDE1 ", 4'd15, 1'b1, 1'b1, 1'b1);
    add_payload(1);
    send_frame(0);
    // match on the last entry allowed
    add_head(1'b0);
    repeat (MAX_PATH_DEF - 1) put_entry("RELAY ", 4'd1, 1'b0, 1'b0, 1'b0);
    put_entry("WIDE2 ", 4'd3, 1'b0, 1'b1, 1'b0);
    add_payload(2);
    send_frame(0);
  endtask

  task automatic test_frame_drops();
    // source entry closes the address field
    add_head(1'b1);
    add_payload(4);
    send_frame(0);
    add_head(1'b1);
    send_frame(0);
    // unmatched entry with its end bit
    add_head(1'b0);
    put_entry("RELAY ", 4'd2, 1'b0, 1'b1, 1'b0);
    add_payload(3);
    send_frame(0);
    // path limit reached without a match; a matching entry after it is ignored
    add_head(1'b0);
    repeat (MAX_PATH_DEF) put_entry("RELAY ", 4'd2, 1'b0, 1'b0, 1'b0);
    put_entry("WIDE1 ", 4'd1, 1'b0, 1'b1, 1'b0);
    add_payload(2);
    send_frame(0);
    // frames cut short in the destination, on the source end and mid path entry
    add_head(1'b0);
    put_entry("WIDE1 ", 4'd1, 1'b0, 1'b1, 1'b0);
    send_frame(1);
    send_frame(5);
    send_frame(HDR_FIXED);
    send_frame(HDR_FIXED + 3);
    // a good frame right after the cut ones
    send_hit_frame("WIDE2 ", 4'd2, 1'b0);
  endtask

  task automatic test_insertion_variants();
    // no own callsign: entry rewritten, nothing inserted
    set_config(1'b1, ALIAS_W1, 1'b1, ALIAS_W2, {8'h00, "CALL0"}, 4'd3);
    send_hit_frame("WIDE1 ", 4'd2, 1'b0);
    // callsign ends early, rest padded; lowest own SSID
    set_config(1'b1, ALIAS_W1, 1'b0, ALIAS_W2, {"AB", 8'h00, "XYZ"}, 4'd0);
    send_hit_frame("WIDE1 ", 4'd1, 1'b0);
    send_hit_frame("WIDE2 ", 4'd1, 1'b0);
    // empty alias matches six spaces; full-length alias; all-ones callsign
    set_config(1'b1, 48'h0, 1'b1, "ABCDEF", 48'hFFFF_FFFF_FFFF, 4'd15);
    send_hit_frame("      ", 4'd2, 1'b0);
    send_hit_frame("ABCDEF", 4'd1, 1'b1);
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_config(1'b1, ALIAS_W1, 1'b1, ALIAS_W2, MY_CALL, 4'd9);
    // largest burst while the receiver holds off, then a long pass-through
    hold_req = HOLD_CYCLES;
    add_head(1'b0);
    repeat (MAX_PATH_DEF - 1) put_entry("RELAY ", 4'd4, 1'b0, 1'b0, 1'b0);
    put_entry("WIDE2 ", 4'd2, 1'b0, 1'b1, 1'b0);
    add_payload(40);
    send_frame(0);
    drain();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_hit_frame("WIDE1 ", 4'd1, 1'b0);
  endtask

  task automatic gen_frame_and_send();
    logic [47:0] nm;
    logic [3:0]  ss;
    int          npath;
    int          plen;
    int          pick;
    int          r;
    int          cut;
    frame_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      // line noise
      add_payload($urandom_range(1, 24));
    end else begin
      r = $urandom_range(0, 9);
      npath = (r == 0) ? 0 : (r == 9) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      put_entry(rand_call(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0);
      put_entry(rand_call(), 4'($urandom_range(0, 15)), 1'b0,
                npath == 0 || $urandom_range(0, 19) == 0, 1'b0);
      for (int i = 0; i < npath; i++) begin
        pick = $urandom_range(0, 3);
        nm = (pick == 0) ? space_pad(shadow_cfg.alias1_name) :
             (pick == 1) ? space_pad(shadow_cfg.alias2_name) : rand_call();
        ss = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        put_entry(nm, ss, 1'($urandom_range(0, 1)), i == npath - 1,
                  1'($urandom_range(0, 1)));
      end
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      add_payload(plen);
    end
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, frame_bytes.size()) : 0;
    send_frame(cut);
  endtask

  task automatic test_random_traffic();
    logic [47:0] nm1;
    logic [47:0] nm2;
    for (int phase = 0; phase < 4; phase++) begin
      nm1 = rand_alias();
      nm2 = rand_alias();
      case (phase)
        0: set_config(1'b1, nm1, 1'b0, nm2, rand_call(), 4'd15);
        1: set_config(1'b0, nm1, 1'b1, nm2, rand_own(), 4'd0);
        2: set_config(1'b1, nm1, 1'b1, nm2, rand_own(), 4'($urandom_range(0, 15)));
        default: set_config(1'b0, nm1, 1'b0, nm2, rand_own(), 4'($urandom_range(0, 15)));
      endcase
      live_items = 0;
      while (live_items < ((phase == 3) ? 10 : 20)) begin
        tx_idle = ($urandom_range(0, 4) != 0);
        rx_idle = ($urandom_range(0, 4) != 0);
        gen_frame_and_send();
        if ($urandom_range(0, 9) == 0) drain();
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_config_regs();
    test_alias_hits();
    test_frame_drops();
    test_insertion_variants();
    test_backpressure();
    test_random_traffic();
    drain();
    if (mismatches == 0) begin
      $display("ax25_wide_n_digipeater_top verification clean");
    end else begin
      $display("ax25_wide_n_digipeater_top verification failed");
    end
    $finish;
  end

endmodule
